/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the pack mode controller. They sample on clk
// and are disabled while rst_n is low. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define BPMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpmc assertion failed");

// Condition must never be true outside reset
`define BPMC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bpmc forbidden condition seen");

`else

`define BPMC_ASSERT(label, prop)
`define BPMC_ASSERT_NEVER(label, cond)

`endif

`endif

/* src/bpmc_pkg.sv */
// ----------------------------------------------------------------------------
// Pack mode controller package
// Types, register indexes and constants shared by the controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpmc_pkg;

  // Field widths
  localparam int MV_W    = 13;
  localparam int TEMP_W  = 9;
  localparam int HYST_W  = 8;
  localparam int CNT_W   = 4;
  localparam int SOC_W   = 7;
  localparam int CIDX_W  = 4;

  // State of charge reload values and undervoltage count ceiling
  localparam logic [SOC_W-1:0] SOC_FULL      = 7'd100;
  localparam logic [SOC_W-1:0] SOC_NEAR_FULL = 7'd95;
  localparam logic [SOC_W-1:0] SOC_NONE      = 7'd0;
  localparam logic [CNT_W-1:0] UNDER_MAX     = 4'd15;

  typedef enum logic [2:0] {
    MODE_BOOT   = 3'd0,
    MODE_READY  = 3'd1,
    MODE_DRIVE  = 3'd2,
    MODE_CHARGE = 3'd3,
    MODE_ERROR  = 3'd4
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_CHARGE_TARGET = 4'd0,
    CFG_RESTART_DROP  = 4'd1,
    CFG_OVER_VOLT     = 4'd2,
    CFG_UNDER_VOLT    = 4'd3,
    CFG_OVER_TEMP     = 4'd4,
    CFG_BAL_MIN_AVG   = 4'd5,
    CFG_BAL_HYST      = 4'd6,
    CFG_UNDER_LIMIT   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]          charge_target_mv;
    logic [MV_W-1:0]          charge_restart_drop_mv;
    logic [MV_W-1:0]          over_volt_mv;
    logic [MV_W-1:0]          under_volt_mv;
    logic signed [TEMP_W-1:0] over_temp_c;
    logic [MV_W-1:0]          balance_min_avg_mv;
    logic [HYST_W-1:0]        balance_hyst_mv;
    logic [CNT_W-1:0]         under_limit_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     key_on;
    logic [MV_W-1:0]          high_cell_mv;
    logic [MV_W-1:0]          low_cell_mv;
    logic [MV_W-1:0]          avg_cell_mv;
    logic signed [TEMP_W-1:0] high_temp_c;
    logic                     second_tick;
  } in_item_t;

  typedef struct packed {
    mode_t            mode;
    logic             charge_flag;
    logic             balance_flag;
    logic [CNT_W-1:0] under_count;
  } ctl_state_t;

  typedef struct packed {
    mode_t            mode;
    logic             charge_request;
    logic             balance_enable;
    logic             soc_set_valid;
    logic [SOC_W-1:0] soc_set_value;
  } result_t;

endpackage

`default_nettype wire

/* src/bpmc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Pack mode controller configuration registers
// Holds the eight threshold registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmc_cfg_regs
  import bpmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [CIDX_W-1:0] wr_index,
  input  wire logic [MV_W-1:0]   wr_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_CHARGE_TARGET: cfg_nxt.charge_target_mv       = wr_data;
        CFG_RESTART_DROP:  cfg_nxt.charge_restart_drop_mv = wr_data;
        CFG_OVER_VOLT:     cfg_nxt.over_volt_mv           = wr_data;
        CFG_UNDER_VOLT:    cfg_nxt.under_volt_mv          = wr_data;
        CFG_OVER_TEMP:     cfg_nxt.over_temp_c            = $signed(wr_data[TEMP_W-1:0]);
        CFG_BAL_MIN_AVG:   cfg_nxt.balance_min_avg_mv     = wr_data;
        CFG_BAL_HYST:      cfg_nxt.balance_hyst_mv        = wr_data[HYST_W-1:0];
        CFG_UNDER_LIMIT:   cfg_nxt.under_limit_ticks      = wr_data[CNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charge_target_mv       <= 13'd4130;
      cfg_r.charge_restart_drop_mv <= 13'd160;
      cfg_r.over_volt_mv           <= 13'd4250;
      cfg_r.under_volt_mv          <= 13'd2000;
      cfg_r.over_temp_c            <= 9'sd149;
      cfg_r.balance_min_avg_mv     <= 13'd3850;
      cfg_r.balance_hyst_mv        <= 8'd7;
      cfg_r.under_limit_ticks      <= 4'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/bpmc_step.sv */
// ----------------------------------------------------------------------------
// Pack mode controller pass logic
// One control pass: mode update, balancing hysteresis, charge end with
// state-of-charge reload, then the one-second undervoltage check.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmc_step
  import bpmc_pkg::*;
(
  input  wire cfg_t       cfg,
  input  wire in_item_t   item,
  input  wire ctl_state_t cur,
  output ctl_state_t      nxt,
  output result_t         res
);

  logic signed [MV_W:0]   high_s, low_s, avg_s, target_s;
  logic signed [MV_W:0]   spread, restart_lvl, full_lvl, hyst_s;
  logic signed [MV_W+1:0] hyst_x5;
  logic [HYST_W+2:0]      hyst5;
  logic                   bal_start, bal_stop, charge_end, uv_hit, uv_fault;
  logic [CNT_W-1:0]       cnt_inc;
  ctl_state_t             upd;
  logic                   soc_valid;
  logic [SOC_W-1:0]       soc_value;

  // Operands as non-negative signed values
  assign high_s   = $signed({1'b0, item.high_cell_mv});
  assign low_s    = $signed({1'b0, item.low_cell_mv});
  assign avg_s    = $signed({1'b0, item.avg_cell_mv});
  assign target_s = $signed({1'b0, cfg.charge_target_mv});
  assign hyst_s   = $signed({{(MV_W+1-HYST_W){1'b0}}, cfg.balance_hyst_mv});

  // Balancing hysteresis: start at spread > 2.5 * hyst, stop at spread <= hyst
  assign spread    = high_s - low_s;
  assign hyst5     = {1'b0, cfg.balance_hyst_mv, 2'b00}
                     + {3'b000, cfg.balance_hyst_mv};
  assign hyst_x5   = $signed({{(MV_W+1-HYST_W-2){1'b0}}, hyst5});
  assign bal_start = $signed({spread, 1'b0}) > hyst_x5;
  assign bal_stop  = spread <= hyst_s;

  // Charge restart and charge end levels
  assign restart_lvl = target_s - $signed({1'b0, cfg.charge_restart_drop_mv});
  assign full_lvl    = target_s - hyst_s;
  assign charge_end  = (high_s > target_s) || (item.high_temp_c > cfg.over_temp_c);

  // Undervoltage tick counting
  assign uv_hit   = (item.low_cell_mv < cfg.under_volt_mv)
                    || (item.high_cell_mv < cfg.under_volt_mv);
  assign cnt_inc  = (cur.under_count != UNDER_MAX) ? cur.under_count + 4'd1
                                                   : cur.under_count;
  assign uv_fault = cnt_inc >= cfg.under_limit_ticks;

  // Mode update
  always_comb begin
    upd       = cur;
    soc_valid = 1'b0;
    soc_value = SOC_NONE;
    unique case (cur.mode)
      MODE_BOOT: begin
        upd.charge_flag = 1'b0;
        upd.mode        = MODE_READY;
      end
      MODE_READY: begin
        upd.charge_flag = 1'b0;
        if (item.avg_cell_mv > cfg.balance_min_avg_mv) begin
          if (bal_start) begin
            upd.balance_flag = 1'b1;
          end else if (bal_stop) begin
            upd.balance_flag = 1'b0;
          end
        end else begin
          upd.balance_flag = 1'b0;
        end
        if (high_s < restart_lvl) begin
          upd.mode = MODE_CHARGE;
        end
        if (item.key_on) begin
          upd.balance_flag = 1'b0;
          upd.mode         = MODE_DRIVE;
        end
      end
      MODE_DRIVE: begin
        if (!item.key_on) begin
          upd.mode = MODE_READY;
        end
      end
      MODE_CHARGE: begin
        upd.balance_flag = 1'b0;
        upd.charge_flag  = 1'b1;
        if (charge_end) begin
          soc_valid       = 1'b1;
          soc_value       = (avg_s > full_lvl) ? SOC_FULL : SOC_NEAR_FULL;
          upd.charge_flag = 1'b0;
          upd.mode        = MODE_READY;
        end
      end
      default: begin
        // error, and any unused code acts as error
        upd.charge_flag = 1'b0;
        if ((item.low_cell_mv > cfg.under_volt_mv)
            && (item.high_cell_mv < cfg.over_volt_mv)) begin
          upd.mode = MODE_READY;
        end
      end
    endcase
  end

  // Undervoltage check runs after the mode update
  always_comb begin
    nxt = upd;
    if (item.second_tick) begin
      if (uv_hit) begin
        nxt.under_count = cnt_inc;
        if (uv_fault) begin
          nxt.mode = MODE_ERROR;
        end
      end else begin
        nxt.under_count = '0;
      end
    end
  end

  assign res.mode           = nxt.mode;
  assign res.charge_request = nxt.charge_flag;
  assign res.balance_enable = nxt.balance_flag;
  assign res.soc_set_valid  = soc_valid;
  assign res.soc_set_value  = soc_value;

endmodule

`default_nettype wire

/* src/battery_pack_mode_controller_top.sv */
// ----------------------------------------------------------------------------
// Battery pack mode controller
// Keeps the pack mode, charge request, balancing flag and undervoltage count.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_*): one transaction is one control pass with key switch,
//  high/low/average cell millivolts, high temperature and second tick.
//  Output channel (out_*): one result per pass: mode, charge request,
//  balance enable and the state-of-charge reload request.
//  Config channel (cfg_*): index and data write, always ready; write only
//  while no pass is in flight. Unknown indexes are ignored.
//  Pipeline: an accepted pass is captured in the input register and moves
//  into the output register once the output register is empty or out_stall
//  is low; out_valid rises as the pass enters the output register.
//  Throughput: one pass per clock while out_stall is low; the per-pass logic is
//  a few compares and the mode update between the input and output registers.
//  Stall: in_stall is raised only when the input register holds a pass and
//  the output register is full and stalled; results are never dropped.
//  Reset (rst_n low, synchronous): mode boot, flags and count cleared,
//  thresholds back to their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module battery_pack_mode_controller_top
  import bpmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     in_key_on,
  input  wire logic [MV_W-1:0]          in_high_cell_mv,
  input  wire logic [MV_W-1:0]          in_low_cell_mv,
  input  wire logic [MV_W-1:0]          in_avg_cell_mv,
  input  wire logic signed [TEMP_W-1:0] in_high_temp_c,
  input  wire logic                     in_second_tick,
  // result channel
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [2:0]               out_mode,
  output      logic                     out_charge_request,
  output      logic                     out_balance_enable,
  output      logic                     out_soc_set_valid,
  output      logic [SOC_W-1:0]         out_soc_set_value,
  // configuration channel
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [MV_W-1:0]          cfg_data
);

  cfg_t       cfg;
  in_item_t   item_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  ctl_state_t state_r, state_nxt;
  result_t    res_r, res_nxt;
  logic       s1_adv, s1_fire, in_fire;
  logic       mode_rdy_or_err, mode_chg_or_err, soc_is_none;

  // Configuration registers
  assign cfg_ready = 1'b1;

  bpmc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline handshake
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.key_on       <= in_key_on;
      item_r.high_cell_mv <= in_high_cell_mv;
      item_r.low_cell_mv  <= in_low_cell_mv;
      item_r.avg_cell_mv  <= in_avg_cell_mv;
      item_r.high_temp_c  <= in_high_temp_c;
      item_r.second_tick  <= in_second_tick;
    end
  end

  // Pass logic
  bpmc_step u_step (
    .cfg  (cfg),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Controller state advances with each pass that moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode         <= MODE_BOOT;
      state_r.charge_flag  <= 1'b0;
      state_r.balance_flag <= 1'b0;
      state_r.under_count  <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = res_r.mode;
  assign out_charge_request = res_r.charge_request;
  assign out_balance_enable = res_r.balance_enable;
  assign out_soc_set_valid  = res_r.soc_set_valid;
  assign out_soc_set_value  = res_r.soc_set_value;

  // Mode groups seen by the checks below
  assign mode_rdy_or_err = (res_r.mode == MODE_READY) || (res_r.mode == MODE_ERROR);
  assign mode_chg_or_err = (res_r.mode == MODE_CHARGE) || (res_r.mode == MODE_ERROR);
  assign soc_is_none     = (out_soc_set_value == SOC_NONE);

  // Assertions
  `BPMC_ASSERT(a_fire_fills_out, s1_fire |=> out_valid_r)
  `BPMC_ASSERT(a_state_holds_idle, !s1_fire |=> $stable(state_r))
  `BPMC_ASSERT(a_soc_after_charge, (out_valid_r && out_soc_set_valid) |-> mode_rdy_or_err)
  `BPMC_ASSERT(a_charge_req_mode, (out_valid_r && out_charge_request) |-> mode_chg_or_err)
  `BPMC_ASSERT_NEVER(a_soc_value_stray, out_valid_r && (out_soc_set_valid == soc_is_none))

endmodule

`default_nettype wire
